// File: rtl/mf3_pkg.sv
// shared constants and types of the 3x3 median filter
`default_nettype none

package mf3_pkg;

  // fixed port widths
  localparam int DATA_W    = 16;
  localparam int COORD_W   = 9;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;

  // frame size after reset, before saturation to the line store size
  localparam int DIM_RESET = 512;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_COLS = 2'd0,
    CFG_IMAGE_ROWS = 2'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

// File: rtl/median_filter_3x3_top.sv
// top level of the streaming 3x3 median filter
`default_nettype none

// Streaming 3x3 median filter. Pixels come in raster order, one word per cycle
// when neither side stalls. Border pixels leave unchanged with their row and
// column; an interior pixel leaves as the median of its 3x3 neighborhood once
// the pixel below-right of it has come in, and the last word of a frame has
// frame_end set. A new pixel is taken every cycle unless a side stalls; a
// pixel that yields two words (last column from row 2 on, and the last row
// from column 2 on) holds the input while its second word is sent, because
// the output register sends at most one word per cycle. From the edge that
// takes a pixel to the edge that loads the output register, the line store is
// read as the pixel is taken, the column sort and window shift fill stage two,
// and the median tree feeds the output register. The two previous rows sit in
// one MAX_WIDTH deep ram of two pixels per entry, read and written once per
// pixel; it needs no clearing pass after reset. Writing either frame size
// register restarts the frame at row 0, column 0.
module median_filter_3x3_top
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  // input words
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [DATA_W-1:0]    pixel_i,
  // output words
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [DATA_W-1:0]    value_o,
  output logic      [COORD_W-1:0]   out_row_o,
  output logic      [COORD_W-1:0]   out_col_o,
  output logic                      frame_end_o
);

  localparam int PW = PIXEL_BITS;
  localparam int AW = $clog2(MAX_WIDTH);        // column counter / ram address
  localparam int RW = $clog2(MAX_HEIGHT);       // row counter
  localparam int CW = $clog2(MAX_WIDTH + 1);    // column count
  localparam int HW = $clog2(MAX_HEIGHT + 1);   // row count
  localparam int XC = (CW > CFG_W) ? CW : CFG_W;
  localparam int XH = (HW > CFG_W) ? HW : CFG_W;
  localparam int COLS_RST = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;
  localparam int ROWS_RST = (MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET;

  typedef logic [PW-1:0] pix_t;

  // compare helpers
  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // saturate a frame size write into 1..max
  function automatic logic [CW-1:0] clamp_cols(input logic [CFG_W-1:0] v);
    logic [XC-1:0] x;
    x = XC'(v);
    if (x == '0) return CW'(1);
    if (x > XC'(MAX_WIDTH)) return CW'(MAX_WIDTH);
    return CW'(x);
  endfunction

  function automatic logic [HW-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [XH-1:0] x;
    x = XH'(v);
    if (x == '0) return HW'(1);
    if (x > XH'(MAX_HEIGHT)) return HW'(MAX_HEIGHT);
    return HW'(x);
  endfunction

  // frame size and position of the next pixel
  logic [CW-1:0] cols_q;
  logic [HW-1:0] rows_q;
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // stage 1: accepted pixel waiting for its line store data
  logic          s1_valid_q, s1_valid_d;
  pix_t          s1_pix_q;
  logic [AW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_med_q, s1_bdr_q, s1_end_q;
  logic          byp_q;
  logic [2*PW-1:0] byp_data_q;

  // stage 2: window of sorted columns and pending words
  pix_t          win_lo_q [3];
  pix_t          win_mid_q[3];
  pix_t          win_hi_q [3];
  pix_t          s2_pix_q;
  logic [AW-1:0] s2_col_q;
  logic [RW-1:0] s2_row_q;
  logic          s2_med_q, s2_bdr_q, s2_end_q;

  // output register
  logic               out_valid_q;
  pix_t               value_q;
  logic [COORD_W-1:0] out_row_q, out_col_q;
  logic               frame_end_q;

  logic          accept, s1_adv, s2_busy, s2_last, out_ready, issue;
  logic          cur_med, cur_bdr, cur_end, col_last, row_last;
  logic [2*PW-1:0] ram_rdata, up_word;
  pix_t          up2, up1, px, new_lo, new_mid, new_hi, median;

  // handshake and pipeline advance
  assign px        = pixel_i[PW-1:0];
  assign out_ready = !out_valid_q || !out_stall_i;
  assign s2_busy   = s2_med_q || s2_bdr_q;
  assign issue     = s2_busy && out_ready;
  assign s2_last   = issue && !(s2_med_q && s2_bdr_q);
  assign s1_adv    = s1_valid_q && (!s2_busy || s2_last);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept    = in_valid_i && !in_stall_o;

  // position flags of the incoming pixel
  assign col_last = (CW'(col_q) + CW'(1)) >= cols_q;
  assign row_last = (HW'(row_q) + HW'(1)) >= rows_q;
  assign cur_med  = (row_q >= RW'(2)) && (col_q >= AW'(2));
  assign cur_bdr  = (row_q == '0) || (col_q == '0) || row_last || col_last;
  assign cur_end  = row_last && col_last;

  // raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  // configuration writes and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CW'(COLS_RST);
      rows_q <= HW'(ROWS_RST);
      col_q  <= '0;
      row_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_COLS: begin
          cols_q <= clamp_cols(cfg_data_i);
          col_q  <= '0;
          row_q  <= '0;
        end
        CFG_IMAGE_ROWS: begin
          rows_q <= clamp_rows(cfg_data_i);
          col_q  <= '0;
          row_q  <= '0;
        end
        default: begin
        end
      endcase
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line store: upper half two rows up, lower half one row up
  mf3_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i ({up1, s1_pix_q}),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // stage 1 control
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        // same entry written by the word ahead in this cycle
        byp_q <= s1_adv && (s1_col_q == col_q);
      end else if (s1_adv) begin
        // stage 1 drains with nothing behind it
        byp_q <= 1'b0;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= px;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_med_q   <= cur_med;
      s1_bdr_q   <= cur_bdr;
      s1_end_q   <= cur_end;
      byp_data_q <= {up1, s1_pix_q};
    end
  end

  // line store data with forwarding, then sort the new column
  always_comb begin
    pix_t lo1, hi1, t;
    up_word = byp_q ? byp_data_q : ram_rdata;
    up2     = up_word[2*PW-1:PW];
    up1     = up_word[PW-1:0];
    lo1     = min2(up2, up1);
    hi1     = max2(up2, up1);
    new_lo  = min2(lo1, s1_pix_q);
    t       = max2(lo1, s1_pix_q);
    new_mid = min2(hi1, t);
    new_hi  = max2(hi1, t);
  end

  // stage 2 control: pending words, median first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_med_q <= 1'b0;
      s2_bdr_q <= 1'b0;
    end else if (s1_adv) begin
      s2_med_q <= s1_med_q;
      s2_bdr_q <= s1_bdr_q;
    end else if (issue) begin
      if (s2_med_q) begin
        s2_med_q <= 1'b0;
      end else begin
        s2_bdr_q <= 1'b0;
      end
    end
  end

  // window shift and stage 2 payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      for (int i = 0; i < 2; i++) begin
        win_lo_q[i]  <= win_lo_q[i+1];
        win_mid_q[i] <= win_mid_q[i+1];
        win_hi_q[i]  <= win_hi_q[i+1];
      end
      win_lo_q[2]  <= new_lo;
      win_mid_q[2] <= new_mid;
      win_hi_q[2]  <= new_hi;
      s2_pix_q     <= s1_pix_q;
      s2_col_q     <= s1_col_q;
      s2_row_q     <= s1_row_q;
      s2_end_q     <= s1_end_q;
    end
  end

  // median of sorted columns
  assign median = med3(max2(max2(win_lo_q[0], win_lo_q[1]), win_lo_q[2]),
                       med3(win_mid_q[0], win_mid_q[1], win_mid_q[2]),
                       min2(min2(win_hi_q[0], win_hi_q[1]), win_hi_q[2]));

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= issue;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      if (s2_med_q) begin
        value_q     <= median;
        out_row_q   <= COORD_W'(s2_row_q - RW'(1));
        out_col_q   <= COORD_W'(s2_col_q - AW'(1));
        frame_end_q <= 1'b0;
      end else begin
        value_q     <= s2_pix_q;
        out_row_q   <= COORD_W'(s2_row_q);
        out_col_q   <= COORD_W'(s2_col_q);
        frame_end_q <= s2_end_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = DATA_W'(value_q);
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign frame_end_o = frame_end_q;

  // raster position always inside the configured frame
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(col_q) < cols_q) && (HW'(row_q) < rows_q))
    else $error("raster position outside frame");

  // a pending median always belongs to a full window
  a_med_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_med_q |-> (s2_row_q >= RW'(2)) && (s2_col_q >= AW'(2)))
    else $error("median pending without full window");

  // forwarded line data only for a word held in stage 1
  a_byp_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> s1_valid_q)
    else $error("forwarding flag without stage 1 word");

  // a word that needs both results keeps the input stalled while it drains
  a_two_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_med_q && s2_bdr_q) |-> in_stall_o)
    else $error("input taken while two words pending");

endmodule

`default_nettype wire

// File: rtl/mf3_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
